// ----- rtl/core/pirmf_pkg.sv -----
// Shared types, byte codes and suffix tables for the read-mode framer.
package pirmf_pkg;

   localparam logic [7:0] ESC_BYTE        = 8'h04;
   localparam logic [7:0] ESC_SF_BYTE     = 8'hF3;
   localparam logic [7:0] ESC_WTD_BYTE    = 8'h11;
   localparam logic [7:0] FLD_CLASS_BYTE  = 8'hD9;
   localparam logic [7:0] FLD_TYPE_BYTE   = 8'h34;
   localparam logic [7:0] CMD_READ_BYTE   = 8'h52;
   localparam logic [7:0] CMD_SFREAD_BYTE = 8'h32;
   localparam logic [7:0] CMD_FLAG_BYTE   = 8'h80;
   localparam logic [7:0] ZERO_BYTE       = 8'h00;
   localparam logic [7:0] SFX_LEN_BYTE    = 8'h08;

   localparam logic [15:0] MIN_FIELD_LEN = 16'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] SFX_LEN_STRUCT = 4'd10;
   localparam logic [3:0] SFX_LEN_ORD    = 4'd4;

   typedef enum logic [1:0] {
      SCAN_SEARCH  = 2'd0,
      SCAN_SAW_WTD = 2'd1,
      SCAN_STOPPED = 2'd2
   } pirmf_scan_type;

   typedef enum logic [1:0] {
      WALK_SEARCH = 2'd0,
      WALK_HEADER = 2'd1,
      WALK_SKIP   = 2'd2,
      WALK_DONE   = 2'd3
   } pirmf_walk_type;

   // One classified record byte handed from the front to the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       invite_req;
      logic       mode;
      logic       invite;
   } pirmf_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pirmf_qstat_type;

   function automatic logic [7:0] pirmf_suffix_byte(input logic mode, input logic [3:0] idx);
      logic [7:0] val;
      val = ZERO_BYTE;
      if (mode) begin
         unique case (idx)
            4'd0:    val = ESC_BYTE;
            4'd1:    val = ESC_SF_BYTE;
            4'd2:    val = ZERO_BYTE;
            4'd3:    val = SFX_LEN_BYTE;
            4'd4:    val = FLD_CLASS_BYTE;
            4'd5:    val = CMD_SFREAD_BYTE;
            4'd6:    val = ZERO_BYTE;
            4'd7:    val = CMD_FLAG_BYTE;
            default: val = ZERO_BYTE;
         endcase
      end else begin
         unique case (idx)
            4'd0:    val = ESC_BYTE;
            4'd1:    val = CMD_READ_BYTE;
            default: val = ZERO_BYTE;
         endcase
      end
      return val;
   endfunction

endpackage

// ----- rtl/core/pirmf_front.sv -----
// Front end: scans each record byte for escapes and walks structured fields.
module pirmf_front #(
   parameter int POSITION_BITS = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   input  logic                    with_invite,
   output pirmf_pkg::pirmf_item_type item
);
   import pirmf_pkg::*;

   localparam int PW = POSITION_BITS;
   localparam int SW = ((PW > 16) ? PW : 16) + 1;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

   logic            mode_ff, mode_in;
   logic            invite_ff, invite_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic            prev_esc_ff, prev_esc_in;
   pirmf_scan_type  scan_ff, scan_in;
   pirmf_walk_type  walk_ff, walk_in;
   logic [1:0]      hcount_ff, hcount_in;
   logic [7:0]      len_hi_ff, len_hi_in;
   logic [15:0]     flen_ff, flen_in;
   logic [7:0]      code_ff, code_in;
   logic [PW-1:0]   next_start_ff, next_start_in;
   logic [PW-1:0]   match_end_ff, match_end_in;

   logic            esc_sf, esc_wtd;
   logic [PW-1:0]   field_start;
   logic [SW-1:0]   field_sum;
   logic [PW-1:0]   field_end;
   logic [PW:0]     pos_plus1;
   logic            match_hit;

   assign esc_sf  = prev_esc_ff && (data_byte == ESC_SF_BYTE);
   assign esc_wtd = prev_esc_ff && (data_byte == ESC_WTD_BYTE);

   // The header's final byte sits three positions after the field start.
   assign field_start = (pos_ff >= PW'(3)) ? (pos_ff - PW'(3)) : '0;
   assign field_sum   = SW'(field_start) + SW'(flen_ff);
   assign field_end   = (field_sum > SW'(POS_MAX)) ? POS_MAX : field_sum[PW-1:0];
   assign pos_plus1   = {1'b0, pos_ff} + (PW+1)'(1);

   always_comb begin
      mode_in       = mode_ff;
      invite_in     = invite_ff;
      scan_in       = scan_ff;
      walk_in       = walk_ff;
      hcount_in     = hcount_ff;
      len_hi_in     = len_hi_ff;
      flen_in       = flen_ff;
      code_in       = code_ff;
      next_start_in = next_start_ff;
      match_end_in  = match_end_ff;
      match_hit     = 1'b0;

      if (scan_ff == SCAN_SEARCH) begin
         if (esc_wtd) begin
            scan_in = SCAN_SAW_WTD;
         end else if (esc_sf) begin
            scan_in = SCAN_STOPPED;
         end
      end

      if ((walk_ff == WALK_SKIP) && (pos_ff == next_start_ff)) begin
         walk_in   = WALK_HEADER;
         hcount_in = 2'd0;
      end

      if (walk_in == WALK_HEADER) begin
         unique case (hcount_in)
            2'd0: len_hi_in = data_byte;
            2'd1: flen_in   = {len_hi_ff, data_byte};
            2'd2: code_in   = data_byte;
            2'd3: begin
               if (flen_ff < MIN_FIELD_LEN) begin
                  walk_in = WALK_DONE;
               end else if ((code_ff == FLD_CLASS_BYTE) && (data_byte == FLD_TYPE_BYTE)) begin
                  match_end_in = field_end;
                  walk_in      = WALK_DONE;
               end else begin
                  next_start_in = field_end;
                  walk_in       = WALK_SKIP;
               end
            end
            default: ;
         endcase
         hcount_in = hcount_in + 2'd1;
      end else if ((walk_in == WALK_SEARCH) && esc_sf) begin
         walk_in   = WALK_HEADER;
         hcount_in = 2'd0;
      end

      prev_esc_in = (data_byte == ESC_BYTE);
      pos_in      = (pos_ff != POS_MAX) ? (pos_ff + PW'(1)) : pos_ff;

      if (last_byte) begin
         match_hit = (match_end_in != '0) && ({1'b0, match_end_in} <= pos_plus1);
         if (match_hit) begin
            mode_in = 1'b1;
         end else if (scan_in == SCAN_SAW_WTD) begin
            mode_in = 1'b0;
         end
         if (with_invite) begin
            invite_in = 1'b1;
         end
         // Per-record state starts over for the next record.
         pos_in        = '0;
         prev_esc_in   = 1'b0;
         scan_in       = SCAN_SEARCH;
         walk_in       = WALK_SEARCH;
         hcount_in     = 2'd0;
         len_hi_in     = '0;
         flen_in       = '0;
         code_in       = '0;
         next_start_in = '0;
         match_end_in  = '0;
      end

      item.data_byte  = data_byte;
      item.last_byte  = last_byte;
      item.invite_req = with_invite;
      item.mode       = mode_in;
      item.invite     = invite_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         invite_ff     <= 1'b0;
         pos_ff        <= '0;
         prev_esc_ff   <= 1'b0;
         scan_ff       <= SCAN_SEARCH;
         walk_ff       <= WALK_SEARCH;
         hcount_ff     <= 2'd0;
         len_hi_ff     <= '0;
         flen_ff       <= '0;
         code_ff       <= '0;
         next_start_ff <= '0;
         match_end_ff  <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         invite_ff     <= invite_in;
         pos_ff        <= pos_in;
         prev_esc_ff   <= prev_esc_in;
         scan_ff       <= scan_in;
         walk_ff       <= walk_in;
         hcount_ff     <= hcount_in;
         len_hi_ff     <= len_hi_in;
         flen_ff       <= flen_in;
         code_ff       <= code_in;
         next_start_ff <= next_start_in;
         match_end_ff  <= match_end_in;
      end
   end

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> ((pos_ff == '0) && (walk_ff == WALK_SEARCH)
                                 && (match_end_ff == '0)))
      else $error("record state not cleared after last byte");
   a_invite_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(invite_ff) |-> invite_ff)
      else $error("invite outstanding flag dropped");
`endif

endmodule

// ----- rtl/core/pirmf_queue.sv -----
// Short queue of classified items between the front and back ends.
module pirmf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  pirmf_pkg::pirmf_item_type  wr_item,
   input  logic                       rd_en,
   output pirmf_pkg::pirmf_item_type  rd_item,
   output pirmf_pkg::pirmf_qstat_type stat
);
   import pirmf_pkg::*;

   pirmf_item_type       mem [QUEUE_DEPTH];
   pirmf_item_type       rd_item_ff;
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? (wr_ptr_ff + QPTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = rd_en ? (rd_ptr_ff + QPTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   assign stat.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_item    = rd_item_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_item;
      end
      // The head entry is read ahead; a write into the slot being read passes straight through.
      if (wr_en && (wr_ptr_ff == rd_ptr_in)) begin
         rd_item_ff <= wr_item;
      end else begin
         rd_item_ff <= mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH)) && !(wr_en && stat.full)
      && !(rd_en && stat.empty))
      else $error("queue overflow or underflow");
`endif

endmodule

// ----- rtl/core/pirmf_back.sv -----
// Back end: emits record bytes and the read command suffix on invite.
module pirmf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pirmf_pkg::pirmf_item_type  q_item,
   input  pirmf_pkg::pirmf_qstat_type q_stat,
   output logic                       q_pop,
   input  logic                       pop,
   output logic                       empty,
   output logic [7:0]                 out_byte,
   output logic                       out_last,
   output logic                       structured_mode,
   output logic                       invite_outstanding
);
   import pirmf_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_mode_ff, out_mode_in;
   logic       out_inv_ff, out_inv_in;
   logic       sfx_active_ff, sfx_active_in;
   logic [3:0] sfx_idx_ff, sfx_idx_in;
   logic       sfx_mode_ff, sfx_mode_in;
   logic       sfx_inv_ff, sfx_inv_in;
   logic       out_free;
   logic [3:0] sfx_len;
   logic       sfx_final;

   assign out_free  = !out_valid_ff || pop;
   assign sfx_len   = sfx_mode_ff ? SFX_LEN_STRUCT : SFX_LEN_ORD;
   assign sfx_final = (sfx_idx_ff == (sfx_len - 4'd1));

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_mode_in   = out_mode_ff;
      out_inv_in    = out_inv_ff;
      sfx_active_in = sfx_active_ff;
      sfx_idx_in    = sfx_idx_ff;
      sfx_mode_in   = sfx_mode_ff;
      sfx_inv_in    = sfx_inv_ff;
      q_pop         = 1'b0;

      if (out_free) begin
         out_valid_in = 1'b0;
         if (sfx_active_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = pirmf_suffix_byte(sfx_mode_ff, sfx_idx_ff);
            out_last_in  = sfx_final;
            out_mode_in  = sfx_mode_ff;
            out_inv_in   = sfx_inv_ff;
            if (sfx_final) begin
               sfx_active_in = 1'b0;
            end else begin
               sfx_idx_in = sfx_idx_ff + 4'd1;
            end
         end else if (!q_stat.empty) begin
            q_pop        = 1'b1;
            out_valid_in = 1'b1;
            out_byte_in  = q_item.data_byte;
            out_last_in  = q_item.last_byte && !q_item.invite_req;
            out_mode_in  = q_item.mode;
            out_inv_in   = q_item.invite;
            // A last byte with invite is followed by the suffix.
            if (q_item.last_byte && q_item.invite_req) begin
               sfx_active_in = 1'b1;
               sfx_idx_in    = 4'd0;
               sfx_mode_in   = q_item.mode;
               sfx_inv_in    = q_item.invite;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         sfx_active_ff <= 1'b0;
         sfx_idx_ff    <= 4'd0;
      end else begin
         out_valid_ff  <= out_valid_in;
         sfx_active_ff <= sfx_active_in;
         sfx_idx_ff    <= sfx_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_mode_ff <= out_mode_in;
      out_inv_ff  <= out_inv_in;
      sfx_mode_ff <= sfx_mode_in;
      sfx_inv_ff  <= sfx_inv_in;
   end

   assign empty              = !out_valid_ff;
   assign out_byte           = out_byte_ff;
   assign out_last           = out_last_ff;
   assign structured_mode    = out_mode_ff;
   assign invite_outstanding = out_inv_ff;

`ifndef SYNTH
   a_sfx_index_range: assert property (@(posedge clock) disable iff (reset)
      sfx_active_ff |-> ((sfx_idx_ff < sfx_len) && out_valid_ff))
      else $error("suffix index out of range or output register empty");
   a_sfx_blocks_queue: assert property (@(posedge clock) disable iff (reset)
      sfx_active_ff |-> !q_pop)
      else $error("queue read while suffix in progress");
`endif

endmodule

// ----- rtl/core/put_invite_read_mode_framer_top.sv -----
// Each accepted byte reaches the rsp ports via the queue read register and the
// back end output register. Sustained rate is one byte per cycle while pop is
// high; a last byte with invite adds a 4- or 10-byte suffix on the result side,
// during which the 4-entry front/back queue can fill and full holds off further
// push transfers. Throughput is set by the back end emitting one byte per cycle.
// Synchronous active-high reset clears control state only; no clearing pass.
module put_invite_read_mode_framer_top #(
   parameter int POSITION_BITS = 17
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_with_invite,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_structured_mode,
   output logic       rsp_invite_outstanding
);
   import pirmf_pkg::*;

   pirmf_item_type  front_item;
   pirmf_item_type  q_item;
   pirmf_qstat_type q_stat;
   logic            accept;
   logic            q_pop;

   assign full   = q_stat.full;
   assign accept = push && !q_stat.full;

   pirmf_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .with_invite (req_with_invite),
      .item        (front_item)
   );

   pirmf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_item (front_item),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .stat    (q_stat)
   );

   pirmf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_item             (q_item),
      .q_stat             (q_stat),
      .q_pop              (q_pop),
      .pop                (pop),
      .empty              (empty),
      .out_byte           (rsp_out_byte),
      .out_last           (rsp_out_last),
      .structured_mode    (rsp_structured_mode),
      .invite_outstanding (rsp_invite_outstanding)
   );

endmodule

// ----- tb/sv/put_invite_read_mode_framer_top_tb.sv -----
// Self-checking testbench for the read-mode framer with invite suffix.
module put_invite_read_mode_framer_top_tb;
   import pirmf_pkg::*;

   localparam int POS_BITS = 17;
   localparam int unsigned POS_MAX = (1 << POS_BITS) - 1;

   localparam logic [79:0] SFX_STRUCT_BYTES = {ESC_BYTE, ESC_SF_BYTE, ZERO_BYTE, SFX_LEN_BYTE,
      FLD_CLASS_BYTE, CMD_SFREAD_BYTE, ZERO_BYTE, CMD_FLAG_BYTE, ZERO_BYTE, ZERO_BYTE};
   localparam logic [31:0] SFX_ORD_BYTES = {ESC_BYTE, CMD_READ_BYTE, ZERO_BYTE, ZERO_BYTE};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       mode;
      logic       invite;
   } out_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       req_with_invite;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_structured_mode;
   logic       rsp_invite_outstanding;

   out_byte_type pending_out_bytes[$];
   logic [7:0]   rec_bytes[$];
   int           mismatch_count = 0;
   int           rsp_hold_cycles = 0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;

   // Framer state as the block should hold it.
   logic                read_structured;
   logic                invite_pending;
   logic [POS_BITS-1:0] rec_pos;
   logic [POS_BITS-1:0] next_start;
   logic [POS_BITS-1:0] match_end;
   logic                prev_esc;
   pirmf_scan_type      scan_st;
   pirmf_walk_type      walk_st;
   logic [1:0]          hdr_idx;
   logic [7:0]          len_hi;
   logic [15:0]         fld_len;
   logic [7:0]          hdr_class;

   put_invite_read_mode_framer_top i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .req_with_invite        (req_with_invite),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_out_last           (rsp_out_last),
      .rsp_structured_mode    (rsp_structured_mode),
      .rsp_invite_outstanding (rsp_invite_outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) begin
         $display("mismatch: %s", msg);
      end
      mismatch_count++;
   endtask

   function automatic void expect_byte(input logic [7:0] b, input logic l);
      out_byte_type e;
      e.data   = b;
      e.last   = l;
      e.mode   = read_structured;
      e.invite = invite_pending;
      pending_out_bytes.insert(pending_out_bytes.size(), e);
   endfunction

   function automatic void add_rec_byte(input logic [7:0] b);
      rec_bytes.insert(rec_bytes.size(), b);
   endfunction

   function automatic void clear_record_scan();
      rec_pos    = '0;
      next_start = '0;
      match_end  = '0;
      prev_esc   = 1'b0;
      scan_st    = SCAN_SEARCH;
      walk_st    = WALK_SEARCH;
      hdr_idx    = '0;
      len_hi     = '0;
      fld_len    = '0;
      hdr_class  = '0;
   endfunction

   // Advances the framer state by one record byte and queues the bytes it emits.
   function automatic void frame_record_byte(input logic [7:0] b, input logic l,
                                             input logic w);
      int unsigned pos;
      int unsigned fld_sum;
      logic        esc_sf;
      logic        esc_wtd;
      int          n_sfx;
      logic [7:0]  sb;
      pos     = 32'(rec_pos);
      esc_sf  = prev_esc && (b == ESC_SF_BYTE);
      esc_wtd = prev_esc && (b == ESC_WTD_BYTE);
      if (scan_st == SCAN_SEARCH) begin
         if (esc_wtd) begin
            scan_st = SCAN_SAW_WTD;
         end else if (esc_sf) begin
            scan_st = SCAN_STOPPED;
         end
      end
      if (walk_st == WALK_SKIP && rec_pos == next_start) begin
         walk_st = WALK_HEADER;
         hdr_idx = '0;
      end
      if (walk_st == WALK_HEADER) begin
         case (hdr_idx)
            2'd0: len_hi = b;
            2'd1: fld_len = {len_hi, b};
            2'd2: hdr_class = b;
            default: begin
               if (fld_len < MIN_FIELD_LEN) begin
                  walk_st = WALK_DONE;
               end else begin
                  // The length counts the header, so the field began three bytes back.
                  fld_sum = ((pos >= 3) ? pos - 3 : 0) + 32'(fld_len);
                  if (fld_sum > POS_MAX) begin
                     fld_sum = POS_MAX;
                  end
                  if (hdr_class == FLD_CLASS_BYTE && b == FLD_TYPE_BYTE) begin
                     match_end = POS_BITS'(fld_sum);
                     walk_st   = WALK_DONE;
                  end else begin
                     next_start = POS_BITS'(fld_sum);
                     walk_st    = WALK_SKIP;
                  end
               end
            end
         endcase
         hdr_idx = hdr_idx + 2'd1;
      end else if (walk_st == WALK_SEARCH && esc_sf) begin
         walk_st = WALK_HEADER;
         hdr_idx = '0;
      end
      prev_esc = (b == ESC_BYTE);
      if (pos < POS_MAX) begin
         rec_pos = rec_pos + POS_BITS'(1);
      end
      if (!l) begin
         expect_byte(b, 1'b0);
         return;
      end
      if (match_end != '0 && match_end <= pos + 1) begin
         read_structured = 1'b1;
      end else if (scan_st == SCAN_SAW_WTD) begin
         read_structured = 1'b0;
      end
      if (w) begin
         invite_pending = 1'b1;
      end
      expect_byte(b, !w);
      if (w) begin
         n_sfx = read_structured ? int'(SFX_LEN_STRUCT) : int'(SFX_LEN_ORD);
         for (int k = 0; k < n_sfx; k++) begin
            sb = read_structured ? SFX_STRUCT_BYTES[79 - 8 * k -: 8]
                                 : SFX_ORD_BYTES[31 - 8 * k -: 8];
            expect_byte(sb, k == n_sfx - 1);
         end
      end
      clear_record_scan();
   endfunction

   // One transfer on the input side; push is left high so the next byte can follow at once.
   task automatic send_byte(input logic [7:0] b, input logic l, input logic w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_data_byte   <= b;
      req_last_byte   <= l;
      req_with_invite <= w;
      do @(posedge clock); while (full);
      frame_record_byte(b, l, w);
   endtask

   task automatic send_record(input logic inv);
      logic l;
      for (int i = 0; i < rec_bytes.size(); i++) begin
         l = (i == rec_bytes.size() - 1);
         send_byte(rec_bytes[i], l, l ? inv : logic'($urandom_range(0, 1)));
      end
   endtask

   task automatic pause_sender_until_drained();
      push <= 1'b0;
      while (pending_out_bytes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Mostly records that open a field walk with random fields; the rest is noise.
   task automatic build_random_record();
      int         n_fields;
      int         flen;
      int         body;
      int         pick;
      logic [7:0] rb;
      logic [7:0] cls;
      logic [7:0] typ;
      rec_bytes.delete();
      repeat ($urandom_range(0, 2)) begin
         pick = $urandom_range(0, 3);
         if (pick == 0) begin
            add_rec_byte(ESC_BYTE);
            add_rec_byte(ESC_WTD_BYTE);
         end else if (pick == 1) begin
            add_rec_byte(ESC_BYTE);
         end else begin
            rb = 8'($urandom);
            add_rec_byte(rb);
         end
      end
      if ($urandom_range(0, 9) < 8) begin
         add_rec_byte(ESC_BYTE);
         add_rec_byte(ESC_SF_BYTE);
         n_fields = $urandom_range(1, 3);
         for (int f = 0; f < n_fields; f++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               flen = $urandom_range(0, 3);
            end else if (pick == 1) begin
               flen = $urandom_range(4, 65535);
            end else begin
               flen = $urandom_range(4, 9);
            end
            pick = $urandom_range(0, 3);
            cls = 8'($urandom);
            typ = 8'($urandom);
            if (pick <= 1) begin
               cls = FLD_CLASS_BYTE;
            end
            if (pick == 0) begin
               typ = FLD_TYPE_BYTE;
            end
            add_rec_byte(flen[15:8]);
            add_rec_byte(flen[7:0]);
            add_rec_byte(cls);
            add_rec_byte(typ);
            body = (flen > 4) ? flen - 4 : 0;
            if (body > 8) begin
               body = $urandom_range(0, 8);
            end
            // Cutting the last body short leaves the field hanging past the record end.
            if (f == n_fields - 1 && body > 0 && $urandom_range(0, 3) == 0) begin
               body = $urandom_range(0, body - 1);
            end
            repeat (body) begin
               rb = 8'($urandom);
               add_rec_byte(($urandom_range(0, 7) == 0) ? ESC_BYTE : rb);
            end
         end
         repeat ($urandom_range(0, 3)) begin
            rb = 8'($urandom);
            add_rec_byte(rb);
         end
      end else begin
         repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 5);
            rb = 8'($urandom);
            if (pick <= 1) begin
               rb = ESC_BYTE;
            end else if (pick == 2) begin
               rb = ESC_SF_BYTE;
            end else if (pick == 3) begin
               rb = ESC_WTD_BYTE;
            end
            add_rec_byte(rb);
         end
      end
   endtask

   task automatic test_directed_records();
      rec_bytes = '{8'hFF};
      send_record(1'b0);
      // A D9 34 field that ends exactly on the last byte.
      rec_bytes = '{ESC_BYTE, ESC_SF_BYTE, 8'h00, 8'h04, FLD_CLASS_BYTE, FLD_TYPE_BYTE};
      send_record(1'b0);
      // The field runs past the record and the late 04 11 is ignored, so the mode is kept.
      rec_bytes = '{ESC_BYTE, ESC_SF_BYTE, 8'h00, 8'h0A, FLD_CLASS_BYTE, FLD_TYPE_BYTE,
                    ESC_BYTE, ESC_WTD_BYTE};
      send_record(1'b1);
      // A 04 11 ahead of the walk with a short field selects ordinary mode.
      rec_bytes = '{ESC_BYTE, ESC_WTD_BYTE, ESC_BYTE, ESC_SF_BYTE, 8'h00, 8'h02,
                    FLD_CLASS_BYTE, FLD_TYPE_BYTE};
      send_record(1'b1);
   endtask

   task automatic test_receiver_hold();
      req_idle_on = 1'b0;
      rsp_hold_cycles = 60;
      rec_bytes = '{ESC_BYTE, ESC_SF_BYTE, 8'h00, 8'h06, FLD_CLASS_BYTE, FLD_TYPE_BYTE,
                    8'h5A, 8'hA5};
      send_record(1'b1);
      repeat (4) begin
         build_random_record();
         send_record(1'b1);
      end
      req_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (3) begin
         build_random_record();
         send_record(1'b1);
         pause_sender_until_drained();
      end
   endtask

   task automatic test_random_records();
      int sent;
      sent = 0;
      while (sent < 270) begin
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = ($urandom_range(0, 4) != 0);
         build_random_record();
         sent += rec_bytes.size();
         send_record(logic'($urandom_range(0, 1)));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset           <= 1'b1;
      push            <= 1'b0;
      req_data_byte   <= 8'h00;
      req_last_byte   <= 1'b0;
      req_with_invite <= 1'b0;
      read_structured = 1'b0;
      invite_pending  = 1'b0;
      clear_record_scan();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_records();
      test_receiver_hold();
      test_sender_pause();
      test_random_records();
      pause_sender_until_drained();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Result side: a random wait before each transfer, or a long hold when one is asked for.
   initial begin : rsp_drain
      int wait_cycles;
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            wait_cycles = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            wait_cycles = rsp_idle_on ? $urandom_range(0, 4) : 0;
         end
         if (wait_cycles > 0) begin
            pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   always @(posedge clock) begin : check_rsp
      out_byte_type want;
      if (!reset && pop && !empty) begin
         if (pending_out_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = pending_out_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, want.data));
            end
            if (rsp_out_last !== want.last) begin
               report_mismatch($sformatf("out_last %b, want %b on byte %02h",
                                         rsp_out_last, want.last, want.data));
            end
            if (rsp_structured_mode !== want.mode) begin
               report_mismatch($sformatf("structured_mode %b, want %b on byte %02h",
                                         rsp_structured_mode, want.mode, want.data));
            end
            if (rsp_invite_outstanding !== want.invite) begin
               report_mismatch($sformatf("invite_outstanding %b, want %b on byte %02h",
                                         rsp_invite_outstanding, want.invite, want.data));
            end
         end
      end
   end

   initial begin
      #(12 * 1000000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
